// ===== design/triangle_normal_and_containment_defines.svh =====
// Assertion macros used by the top-level block.
`ifndef TRIANGLE_NORMAL_AND_CONTAINMENT_DEFINES_SVH
`define TRIANGLE_NORMAL_AND_CONTAINMENT_DEFINES_SVH
`define TNC_ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("assertion failed");
`define TNC_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("assertion failed");
`endif

// ===== design/tnc_pkg.sv =====
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared constants for the triangle normal and containment block.
// ----------------------------------------------------------------------------
`default_nettype none
package tnc_pkg;
  localparam int OUT_WIDTH = 16;
endpackage
`default_nettype wire

// ===== design/tnc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tnc_sqrt_cell
// One bit decision of the normal magnitude search for all three axes.
// ----------------------------------------------------------------------------
`default_nettype none
module tnc_sqrt_cell
  import tnc_pkg::*;
#(
  parameter int KW  = 16,
  parameter int DW  = 140,
  parameter int TW  = 160,
  parameter int BIT = 0,
  parameter int PW  = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire logic [DW-1:0]    d_i,
  input  wire logic [TW-1:0]    tgt_i [3],
  input  wire logic [KW-1:0]    k_i [3],
  input  wire logic [TW-1:0]    pp_i [3],
  input  wire logic [DW+KW-1:0] qq_i [3],
  input  wire logic [PW-1:0]    pass_i,
  output logic                  vld_o,
  output logic [DW-1:0]         d_o,
  output logic [TW-1:0]         tgt_o [3],
  output logic [KW-1:0]         k_o [3],
  output logic [TW-1:0]         pp_o [3],
  output logic [DW+KW-1:0]      qq_o [3],
  output logic [PW-1:0]         pass_o
);
  localparam int CW = DW + 2 * KW;
  localparam int QW = DW + KW;

  logic [KW-1:0] k_nxt [3];
  logic [TW-1:0] pp_nxt [3];
  logic [QW-1:0] qq_nxt [3];
  logic          vld_r;
  logic [DW-1:0] d_r;
  logic [TW-1:0] tgt_r [3];
  logic [KW-1:0] k_r [3];
  logic [TW-1:0] pp_r [3];
  logic [QW-1:0] qq_r [3];
  logic [PW-1:0] pass_r;

  // The running k*k*d and k*d let the trial square be formed by shifts and adds.
  always_comb begin
    logic [CW-1:0] cand;
    for (int i = 0; i < 3; i++) begin
      cand = CW'(pp_i[i]) + (CW'(qq_i[i]) << (BIT + 1)) + (CW'(d_i) << (2 * BIT));
      if (cand <= CW'(tgt_i[i])) begin
        k_nxt[i] = k_i[i] | (KW'(1) << BIT);
        pp_nxt[i] = TW'(cand);
        qq_nxt[i] = qq_i[i] + (QW'(d_i) << BIT);
      end else begin
        k_nxt[i] = k_i[i];
        pp_nxt[i] = pp_i[i];
        qq_nxt[i] = qq_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      d_r <= d_i;
      tgt_r <= tgt_i;
      k_r <= k_nxt;
      pp_r <= pp_nxt;
      qq_r <= qq_nxt;
      pass_r <= pass_i;
    end
  end

  assign vld_o = vld_r;
  assign d_o = d_r;
  assign tgt_o = tgt_r;
  assign k_o = k_r;
  assign pp_o = pp_r;
  assign qq_o = qq_r;
  assign pass_o = pass_r;
endmodule
`default_nettype wire

// ===== design/triangle_normal_and_containment.sv =====
// ----------------------------------------------------------------------------
// triangle_normal_and_containment
// Unit face normal and barycentric containment of a query point.
// ----------------------------------------------------------------------------
// One input word carries three corners and a query point; one output word
// carries the unit normal, the inside flag and the degenerate flag.
// Both channels use valid and ready. The pipeline advances whenever the
// output register is empty or being taken, so one word enters per cycle.
// The pipeline has four arithmetic stages, then one cell per result bit in
// the magnitude search chain.
// Throughput is one word per cycle, set by the fully pipelined chain.
// Reset clears every valid bit; payload registers are not reset.
// When the receiver stalls, the whole pipeline holds and in_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_normal_and_containment_defines.svh"
module triangle_normal_and_containment
  import tnc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_a_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_b_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_c_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_c_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_c_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_query_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_query_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_query_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [OUT_WIDTH-1:0]        out_normal_x,
  output logic signed [OUT_WIDTH-1:0]        out_normal_y,
  output logic signed [OUT_WIDTH-1:0]        out_normal_z,
  output logic                               out_inside_res,
  output logic                               out_degenerate
);
  localparam int XW = COORD_WIDTH + 1;
  localparam int NW = 2 * XW + 1;
  localparam int DW = 2 * NW + 2;
  localparam int KW = NORMAL_FRAC_BITS + 2;
  localparam int TW = 2 * NW + 2 * NORMAL_FRAC_BITS;
  localparam int UW = NW + DW + 2;
  localparam int NC = NORMAL_FRAC_BITS + 1;
  localparam int QW = DW + KW;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: edge vectors.
  logic s1_vld_r;
  logic signed [XW-1:0] a_r [3], x_r [3], y_r [3], p_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_valid;
    if (en) begin
      a_r[0] <= XW'(in_corner_a_x); a_r[1] <= XW'(in_corner_a_y);
      a_r[2] <= XW'(in_corner_a_z);
      x_r[0] <= XW'(in_corner_b_x) - XW'(in_corner_a_x);
      x_r[1] <= XW'(in_corner_b_y) - XW'(in_corner_a_y);
      x_r[2] <= XW'(in_corner_b_z) - XW'(in_corner_a_z);
      y_r[0] <= XW'(in_corner_c_x) - XW'(in_corner_a_x);
      y_r[1] <= XW'(in_corner_c_y) - XW'(in_corner_a_y);
      y_r[2] <= XW'(in_corner_c_z) - XW'(in_corner_a_z);
      p_r[0] <= XW'(in_query_x) - XW'(in_corner_a_x);
      p_r[1] <= XW'(in_query_y) - XW'(in_corner_a_y);
      p_r[2] <= XW'(in_query_z) - XW'(in_corner_a_z);
    end
  end

  // Stage 2: crosses.
  logic s2_vld_r;
  logic signed [NW-1:0] n_r [3], tu_r [3], tv_r [3];
  logic signed [XW-1:0] a2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
    if (en) begin
      a2_r <= a_r;
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NW'(x_r[(i+1)%3]) * NW'(y_r[(i+2)%3])
                - NW'(x_r[(i+2)%3]) * NW'(y_r[(i+1)%3]);
        tu_r[i] <= NW'(p_r[(i+1)%3]) * NW'(y_r[(i+2)%3])
                 - NW'(p_r[(i+2)%3]) * NW'(y_r[(i+1)%3]);
        tv_r[i] <= NW'(x_r[(i+1)%3]) * NW'(p_r[(i+2)%3])
                 - NW'(x_r[(i+2)%3]) * NW'(p_r[(i+1)%3]);
      end
    end
  end

  // Stage 3: dot products.
  logic s3_vld_r;
  logic signed [UW-1:0] d_r, u_r, v_r, an_r;
  logic signed [NW-1:0] n3_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= s2_vld_r;
    if (en) begin
      n3_r <= n_r;
      d_r <= UW'(n_r[0]) * UW'(n_r[0]) + UW'(n_r[1]) * UW'(n_r[1])
           + UW'(n_r[2]) * UW'(n_r[2]);
      u_r <= UW'(tu_r[0]) * UW'(n_r[0]) + UW'(tu_r[1]) * UW'(n_r[1])
           + UW'(tu_r[2]) * UW'(n_r[2]);
      v_r <= UW'(tv_r[0]) * UW'(n_r[0]) + UW'(tv_r[1]) * UW'(n_r[1])
           + UW'(tv_r[2]) * UW'(n_r[2]);
      an_r <= UW'(a2_r[0]) * UW'(n_r[0]) + UW'(a2_r[1]) * UW'(n_r[1])
            + UW'(a2_r[2]) * UW'(n_r[2]);
    end
  end

  // Stage 4: flags, orientation and search targets.
  logic s4_vld_r;
  logic [DW-1:0] d4_r;
  logic [TW-1:0] tgt4_r [3];
  logic [1:0] pass4_r;
  logic [2:0] neg4_r;
  always_ff @(posedge clk) begin
    logic flip;
    logic signed [NW-1:0] nn;
    logic [NW-1:0] mag;
    flip = an_r < 0;
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (en) s4_vld_r <= s3_vld_r;
    if (en) begin
      d4_r <= DW'(d_r);
      pass4_r[1] <= (d_r == 0);
      pass4_r[0] <= (d_r != 0) && (u_r >= 0) && (v_r >= 0) && (u_r + v_r <= d_r);
      for (int i = 0; i < 3; i++) begin
        nn = flip ? -n3_r[i] : n3_r[i];
        mag = nn[NW-1] ? NW'(-nn) : NW'(nn);
        neg4_r[i] <= nn[NW-1];
        tgt4_r[i] <= (TW'(mag) * TW'(mag)) << (2 * NORMAL_FRAC_BITS);
      end
    end
  end

  logic          c_vld [NC+1];
  logic [DW-1:0] c_d [NC+1];
  logic [TW-1:0] c_t [NC+1][3];
  logic [KW-1:0] c_k [NC+1][3];
  logic [TW-1:0] c_pp [NC+1][3];
  logic [QW-1:0] c_qq [NC+1][3];
  logic [4:0]    c_p [NC+1];
  assign c_vld[0] = s4_vld_r;
  assign c_d[0] = d4_r;
  assign c_t[0] = tgt4_r;
  assign c_k[0][0] = '0;
  assign c_k[0][1] = '0;
  assign c_k[0][2] = '0;
  assign c_pp[0][0] = '0;
  assign c_pp[0][1] = '0;
  assign c_pp[0][2] = '0;
  assign c_qq[0][0] = '0;
  assign c_qq[0][1] = '0;
  assign c_qq[0][2] = '0;
  assign c_p[0] = {neg4_r, pass4_r};

  for (genvar g = 0; g < NC; g++) begin : g_cell
    tnc_sqrt_cell #(.KW(KW), .DW(DW), .TW(TW), .BIT(NORMAL_FRAC_BITS - g), .PW(5)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(c_vld[g]), .d_i(c_d[g]), .tgt_i(c_t[g]), .k_i(c_k[g]),
      .pp_i(c_pp[g]), .qq_i(c_qq[g]), .pass_i(c_p[g]),
      .vld_o(c_vld[g+1]), .d_o(c_d[g+1]), .tgt_o(c_t[g+1]), .k_o(c_k[g+1]),
      .pp_o(c_pp[g+1]), .qq_o(c_qq[g+1]), .pass_o(c_p[g+1])
    );
  end

  logic [OUT_WIDTH-1:0] nr [3];
  always_comb begin
    logic [KW-1:0] k;
    for (int i = 0; i < 3; i++) begin
      k = c_p[NC][2+i] ? KW'(-c_k[NC][i]) : c_k[NC][i];
      nr[i] = c_p[NC][1] ? '0 : OUT_WIDTH'({{OUT_WIDTH{k[KW-1] & c_p[NC][2+i]}}, k});
    end
  end

  assign out_valid = c_vld[NC];
  assign out_normal_x = nr[0];
  assign out_normal_y = nr[1];
  assign out_normal_z = nr[2];
  assign out_inside_res = c_p[NC][0];
  assign out_degenerate = c_p[NC][1];

  `TNC_ASSERT_IMPL(a_degen_zero, out_valid && out_degenerate, !out_inside_res && out_normal_x == 0)
  `TNC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_normal_y))
  `TNC_ASSERT_IMPL(a_ready, !out_valid, in_ready)
endmodule
`default_nettype wire

// ===== sim/triangle_normal_and_containment_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_normal_and_containment_tb
// Self-checking bench for the triangle normal and containment block.
// ----------------------------------------------------------------------------
// Directed corner cases, then random triangles, drive the input channel in
// bursts while the output channel stalls on its own pattern. Every accepted
// word is predicted in exact integer arithmetic and the results are checked
// in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class tri_scoreboard;
  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic in_tri, degen;
  } tri_result_t;

  tri_result_t pending[$];
  int errors;
  int checked;
  int degen_seen;
  int inside_seen;

  function new();
    errors = 0;
    checked = 0;
    degen_seen = 0;
    inside_seen = 0;
  endfunction

  // Largest k with k*k*d <= n*n*4^14.
  function automatic logic [15:0] unit_mag(logic signed [127:0] n, logic signed [127:0] d);
    logic signed [127:0] target;
    logic signed [127:0] t;
    logic [15:0] k;
    target = (n * n) <<< 28;
    k = 0;
    for (int b = 14; b >= 0; b--) begin
      t = k | (16'd1 << b);
      if (t * t * d <= target) begin
        k = t[15:0];
      end
    end
    return k;
  endfunction

  function automatic void note_input(logic signed [15:0] w[12]);
    logic signed [127:0] a[3], x[3], y[3], p[3], n[3], t[3];
    logic signed [127:0] d, u, v, an;
    logic [15:0] k[3];
    tri_result_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = w[i];
      x[i] = 128'(w[3 + i]) - a[i];
      y[i] = 128'(w[6 + i]) - a[i];
      p[i] = 128'(w[9 + i]) - a[i];
    end
    n[0] = x[1] * y[2] - x[2] * y[1];
    n[1] = x[2] * y[0] - x[0] * y[2];
    n[2] = x[0] * y[1] - x[1] * y[0];
    d = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    if (d == 0) begin
      r = '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1};
    end else begin
      t[0] = p[1] * y[2] - p[2] * y[1];
      t[1] = p[2] * y[0] - p[0] * y[2];
      t[2] = p[0] * y[1] - p[1] * y[0];
      u = t[0] * n[0] + t[1] * n[1] + t[2] * n[2];
      t[0] = x[1] * p[2] - x[2] * p[1];
      t[1] = x[2] * p[0] - x[0] * p[2];
      t[2] = x[0] * p[1] - x[1] * p[0];
      v = t[0] * n[0] + t[1] * n[1] + t[2] * n[2];
      r.in_tri = (u >= 0) && (v >= 0) && (u + v <= d);
      r.degen = 1'b0;
      an = a[0] * n[0] + a[1] * n[1] + a[2] * n[2];
      for (int i = 0; i < 3; i++) begin
        if (an < 0) begin
          n[i] = -n[i];
        end
        k[i] = unit_mag(n[i], d);
        if (n[i] < 0) begin
          k[i] = -k[i];
        end
      end
      r.nx = k[0];
      r.ny = k[1];
      r.nz = k[2];
    end
    pending = {pending, r};
  endfunction

  function automatic void check_result(logic signed [15:0] nx, logic signed [15:0] ny,
                                       logic signed [15:0] nz, logic in_tri, logic degen);
    tri_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word nx=%0d ny=%0d nz=%0d", $time, nx, ny, nz);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    degen_seen += degen;
    inside_seen += in_tri;
    if (nx !== e.nx) begin
      $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, nx);
      errors++;
    end
    if (ny !== e.ny) begin
      $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, ny);
      errors++;
    end
    if (nz !== e.nz) begin
      $display("%0t: normal_z expected %0d actual %0d", $time, e.nz, nz);
      errors++;
    end
    if (in_tri !== e.in_tri) begin
      $display("%0t: inside_res expected %0b actual %0b", $time, e.in_tri, in_tri);
      errors++;
    end
    if (degen !== e.degen) begin
      $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, degen);
      errors++;
    end
  endfunction
endclass

module triangle_normal_and_containment_tb;
  import tnc_pkg::*;

  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] coord[12];
  logic out_valid;
  logic out_ready;
  logic signed [OUT_WIDTH-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_inside_res;
  logic out_degenerate;

  tri_scoreboard sb;
  int cycles;
  int words_sent;

  triangle_normal_and_containment u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_corner_a_x(coord[0]),
    .in_corner_a_y(coord[1]),
    .in_corner_a_z(coord[2]),
    .in_corner_b_x(coord[3]),
    .in_corner_b_y(coord[4]),
    .in_corner_b_z(coord[5]),
    .in_corner_c_x(coord[6]),
    .in_corner_c_y(coord[7]),
    .in_corner_c_z(coord[8]),
    .in_query_x(coord[9]),
    .in_query_y(coord[10]),
    .in_query_z(coord[11]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z),
    .out_inside_res(out_inside_res),
    .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stall pattern: alternating stretches of full rate and random stalls.
  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 200) % 3 == 0) begin
        out_ready <= 1'b1;
      end else if ((phase / 200) % 3 == 1) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_normal_x, out_normal_y, out_normal_z, out_inside_res,
                      out_degenerate);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_normal_and_containment test failed");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic signed [15:0] w[12]);
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      coord[i] <= w[i];
    end
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 512))) - 16'sd256;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 16))) - 16'sd8;
    endcase
  endfunction

  task automatic make_random(output logic signed [15:0] w[12]);
    int mode;
    int shape;
    mode = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) begin
      w[i] = rand_coord(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : mode);
    end
    if (shape == 0) begin
      // Collinear corners give a zero-area triangle.
      for (int i = 0; i < 3; i++) begin
        w[6 + i] = 16'(w[i] + 2 * (w[3 + i] - w[i]));
      end
    end else if (shape == 1) begin
      for (int i = 0; i < 3; i++) begin
        w[3 + i] = w[i];
      end
    end else if (shape <= 5) begin
      // Query point near the centroid, usually inside.
      for (int i = 0; i < 3; i++) begin
        w[9 + i] = 16'((32'(w[i]) + w[3 + i] + w[6 + i]) / 3
                       + $signed($urandom_range(0, 4)) - 2);
      end
    end else if (shape == 6) begin
      w[9 + $urandom_range(0, 2)] = w[$urandom_range(0, 8)];
      for (int i = 0; i < 3; i++) begin
        w[9 + i] = w[3 * $urandom_range(0, 2) + i];
      end
    end
  endtask

  initial begin
    logic signed [15:0] w[12];
    int burst;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    for (int i = 0; i < 12; i++) begin
      coord[i] = '0;
    end
    words_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, all-zero, collinear, query on a corner, a.N = 0.
    w = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_word(w);
    w = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0000,
          16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_word(w);
    w = '{default: 16'sd0};
    send_word(w);
    w = '{0, 0, 0, 256, 0, 0, 512, 0, 0, 128, 0, 0};
    send_word(w);
    w = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 0};
    send_word(w);
    w = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0};
    send_word(w);
    w = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 200, 200, 0};
    send_word(w);
    w = '{0, 0, 0, 256, 0, 0, 0, 256, 0, -1, 10, 0};
    send_word(w);
    w = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 128, 0};
    send_word(w);
    w = '{0, 0, 256, 256, 0, 256, 0, 256, 256, 10, 10, -5000};
    send_word(w);
    w = '{0, 0, -256, 0, 256, -256, 256, 0, -256, 10, 10, 0};
    send_word(w);
    w = '{100, 100, 100, 200, 300, 400, 700, 100, -300, -1, -1, -1};
    send_word(w);
    w = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff, 100, 100, 100};
    send_word(w);
    w = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_word(w);
    w = '{-1, -1, -1, 1, 1, 1, 1, -1, 0, 16'sh5555, 16'shaaaa, 16'sh5555};
    send_word(w);
    w = '{3, 7, -2, 3, 7, -1, 3, 8, -2, 16'shaaaa, 16'sh5555, 16'shaaaa};
    send_word(w);
    idle_cycles($urandom_range(1, 5));

    // Random part in bursts with random gaps.
    while (words_sent < RANDOM_WORDS + 16) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        make_random(w);
        send_word(w);
      end
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("Checked %0d results from %0d words: %0d degenerate, %0d inside.",
             sb.checked, words_sent, sb.degen_seen, sb.inside_seen);
    if (sb.errors == 0) begin
      $display("triangle_normal_and_containment test passed");
    end else begin
      $display("triangle_normal_and_containment test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
